FILE: rtl/clarke_park_transform_unit_top_defines.svh
// Assertion macros shared by the Clarke/Park transform unit RTL.
`ifndef CLARKE_PARK_TRANSFORM_UNIT_TOP_DEFINES_SVH
`define CLARKE_PARK_TRANSFORM_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define CPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define CPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define CPT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/cpt_pkg.sv
// Shared types, constants and the sine table for the Clarke/Park transform unit.
package cpt_pkg;

  localparam int DATA_WIDTH       = 16;
  localparam int TRIG_W           = 16;
  localparam int ANGLE_W          = 16;
  localparam int ANGLE_FRAC_W     = ANGLE_W - 2;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH + 1);

  // Coefficients in Q2.30.
  localparam int COEF_W = 32;
  localparam logic signed [COEF_W-1:0] INV_SQRT3_Q30     = 32'sd619925131;
  localparam logic signed [COEF_W-1:0] TWO_INV_SQRT3_Q30 = 32'sd1239850262;
  localparam logic signed [COEF_W-1:0] SQRT3_HALF_Q30    = 32'sd929887697;
  localparam logic signed [COEF_W-1:0] NEG_HALF_Q30      = -32'sd536870912;

  localparam int PROD_W = DATA_WIDTH + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam int SHIFT_CLARKE = 30;
  localparam int SHIFT_PARK   = 15;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_CLARKE  = 2'd0;
  localparam mode_t MODE_ICLARKE = 2'd1;
  localparam mode_t MODE_PARK    = 2'd2;
  localparam mode_t MODE_IPARK   = 2'd3;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_val;
    logic signed [TRIG_W-1:0] cos_val;
  } trig_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         clip;
  } sat_t;

  typedef logic signed [TRIG_W-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  localparam longint unsigned HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam longint unsigned LOW32       = 64'h00000000FFFFFFFF;

  // Q2.62 by Q2.62 product, kept in Q2.62; used only while building the table.
  function automatic longint unsigned mul_q62(longint unsigned a, longint unsigned b);
    longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = a & LOW32;
    ah  = a >> 32;
    bl  = b & LOW32;
    bh  = b >> 32;
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + (lh & LOW32) + (hl & LOW32);
    lo  = (ll & LOW32) | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // Truncating unsigned quotient by restoring long division; the divisor is
  // small, so the partial remainder never overflows. Used only for the table.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | {63'd0, num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine table, Q1.15, built with a Taylor series at elaboration.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x, x2, term, acc, v, k64, den;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      k64  = longint'(k);
      x    = (HALF_PI_Q62 / SINE_TABLE_DEPTH) * k64
           + ((HALF_PI_Q62 % SINE_TABLE_DEPTH) * k64) / SINE_TABLE_DEPTH;
      x2   = mul_q62(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
        den  = longint'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q62(term, x2), den);
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc + (64'd1 << 46)) >> 47;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      tab[k] = TRIG_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

FILE: rtl/clarke_park_transform_unit_top.sv
// A request passes the input, sine/cosine, products and output registers in that order.
// Throughput: one request per cycle while out_stall is low; four registered stages, each
// gated by its own valid, so an empty stage keeps taking requests.
// The sine table is constant logic; stall on the output backs up stage by stage.
// Reset (rst, synchronous) clears all stage valids; payload registers are not reset.
`include "clarke_park_transform_unit_top_defines.svh"

module clarke_park_transform_unit_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic signed [cpt_pkg::DATA_WIDTH-1:0]  first_in,
  input  logic signed [cpt_pkg::DATA_WIDTH-1:0]  second_in,
  input  logic [cpt_pkg::ANGLE_W-1:0]            angle,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cpt_pkg::DATA_WIDTH-1:0]  first_out,
  output logic signed [cpt_pkg::DATA_WIDTH-1:0]  second_out,
  output logic signed [cpt_pkg::DATA_WIDTH-1:0]  third_out,
  output logic                                   saturated
);

  localparam int DW = cpt_pkg::DATA_WIDTH;
  localparam int CW = cpt_pkg::COEF_W;
  localparam int PW = cpt_pkg::PROD_W;
  localparam int SW = cpt_pkg::SUM_W;

  // Each stage may load when it is empty or when the stage after it loads.
  // The chain runs back from the output register, so a request in flight
  // never waits behind a bubble.
  logic load1, load2, load3, load4;
  logic valid1, valid2, valid3, valid4;

  assign load4    = !valid4 || !out_stall;
  assign load3    = !valid3 || load4;
  assign load2    = !valid2 || load3;
  assign load1    = !valid1 || load2;
  assign in_stall = !load1;
  assign out_valid = valid4;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else begin
      if (load1) valid1 <= in_valid;
      if (load2) valid2 <= valid1;
      if (load3) valid3 <= valid2;
      if (load4) valid4 <= valid3;
    end
  end

  // Stage 1: the request as it arrived.
  cpt_pkg::mode_t          stage1_mode;
  logic signed [DW-1:0]    stage1_first;
  logic signed [DW-1:0]    stage1_second;
  logic [cpt_pkg::ANGLE_W-1:0] stage1_angle;

  always_ff @(posedge clk) begin
    if (load1) begin
      stage1_mode   <= mode;
      stage1_first  <= first_in;
      stage1_second <= second_in;
      stage1_angle  <= angle;
    end
  end

  // Stage 2: sine and cosine of the rotor angle from the table. The lookup is
  // done for every mode; the Clarke modes simply ignore it.
  cpt_pkg::trig_t trig_next;

  cpt_sincos u_sincos (
    .angle (stage1_angle),
    .trig  (trig_next)
  );

  cpt_pkg::mode_t       stage2_mode;
  logic signed [DW-1:0] stage2_first;
  logic signed [DW-1:0] stage2_second;
  cpt_pkg::trig_t       stage2_trig;

  always_ff @(posedge clk) begin
    if (load2) begin
      stage2_mode   <= stage1_mode;
      stage2_first  <= stage1_first;
      stage2_second <= stage1_second;
      stage2_trig   <= trig_next;
    end
  end

  // Stage 3: four products. The Clarke modes use fixed Q2.30 coefficients,
  // the rotations use sine and cosine in Q1.15. The first product always
  // takes the first operand and the second the second operand, so the sums
  // in the next stage are a fixed pattern per mode.
  logic signed [CW-1:0] coef0, coef1, coef2, coef3;
  logic signed [CW-1:0] sin_ext, cos_ext;

  assign sin_ext = CW'(stage2_trig.sin_val);
  assign cos_ext = CW'(stage2_trig.cos_val);

  always_comb begin
    unique case (stage2_mode)
      cpt_pkg::MODE_CLARKE: begin
        coef0 = cpt_pkg::INV_SQRT3_Q30;
        coef1 = cpt_pkg::TWO_INV_SQRT3_Q30;
        coef2 = '0;
        coef3 = '0;
      end
      cpt_pkg::MODE_ICLARKE: begin
        coef0 = cpt_pkg::NEG_HALF_Q30;
        coef1 = cpt_pkg::SQRT3_HALF_Q30;
        coef2 = '0;
        coef3 = '0;
      end
      cpt_pkg::MODE_PARK, cpt_pkg::MODE_IPARK: begin
        coef0 = cos_ext;
        coef1 = sin_ext;
        coef2 = sin_ext;
        coef3 = cos_ext;
      end
    endcase
  end

  logic signed [PW-1:0] prod0_next, prod1_next, prod2_next, prod3_next;

  assign prod0_next = PW'(stage2_first)  * PW'(coef0);
  assign prod1_next = PW'(stage2_second) * PW'(coef1);
  assign prod2_next = PW'(stage2_first)  * PW'(coef2);
  assign prod3_next = PW'(stage2_second) * PW'(coef3);

  cpt_pkg::mode_t       stage3_mode;
  logic signed [DW-1:0] stage3_first;
  logic signed [PW-1:0] prod0, prod1, prod2, prod3;

  always_ff @(posedge clk) begin
    if (load3) begin
      stage3_mode  <= stage2_mode;
      stage3_first <= stage2_first;
      prod0        <= prod0_next;
      prod1        <= prod1_next;
      prod2        <= prod2_next;
      prod3        <= prod3_next;
    end
  end

  // Stage 4: sums, one rounding each, saturation. In the Clarke modes the
  // first result passes the first operand through; it is lined up at the
  // same binary point so that it goes through the same rounding unit and
  // comes back unchanged.
  logic signed [SW-1:0] sum0, sum1, sum2;
  logic signed [SW-1:0] p0_ext, p1_ext, p2_ext, p3_ext, first_aligned;
  logic                 park_shift;

  assign p0_ext        = SW'(prod0);
  assign p1_ext        = SW'(prod1);
  assign p2_ext        = SW'(prod2);
  assign p3_ext        = SW'(prod3);
  assign first_aligned = SW'(stage3_first) <<< cpt_pkg::SHIFT_CLARKE;
  assign park_shift    = (stage3_mode == cpt_pkg::MODE_PARK) ||
                         (stage3_mode == cpt_pkg::MODE_IPARK);

  always_comb begin
    unique case (stage3_mode)
      cpt_pkg::MODE_CLARKE: begin
        sum0 = first_aligned;
        sum1 = p0_ext + p1_ext;
        sum2 = '0;
      end
      cpt_pkg::MODE_ICLARKE: begin
        sum0 = first_aligned;
        sum1 = p0_ext + p1_ext;
        sum2 = p0_ext - p1_ext;
      end
      cpt_pkg::MODE_PARK: begin
        sum0 = p0_ext + p1_ext;
        sum1 = p3_ext - p2_ext;
        sum2 = '0;
      end
      cpt_pkg::MODE_IPARK: begin
        sum0 = p0_ext - p1_ext;
        sum1 = p2_ext + p3_ext;
        sum2 = '0;
      end
    endcase
  end

  cpt_pkg::sat_t res0, res1, res2;

  cpt_round_sat u_round0 (.sum(sum0), .park(park_shift), .result(res0));
  cpt_round_sat u_round1 (.sum(sum1), .park(park_shift), .result(res1));
  cpt_round_sat u_round2 (.sum(sum2), .park(park_shift), .result(res2));

  always_ff @(posedge clk) begin
    if (load4) begin
      first_out  <= res0.value;
      second_out <= res1.value;
      third_out  <= res2.value;
      saturated  <= res0.clip | res1.clip | res2.clip;
    end
  end

  // An accepted request always lands in the input stage.
  `CPT_ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && !in_stall, valid1)
  // A request held in the input stage keeps its operands.
  `CPT_ASSERT_NEXT(a_stage1_holds, clk, rst, valid1 && !load2, valid1 && $stable(stage1_first))
  // Sine and cosine are never zero together.
  `CPT_ASSERT_IMPL(a_trig_nonzero, clk, rst, valid2,
                   stage2_trig.sin_val != 0 || stage2_trig.cos_val != 0)
  // Only the inverse Clarke transform produces a third phase.
  `CPT_ASSERT_IMPL(a_third_only_iclarke, clk, rst,
                   valid3 && stage3_mode != cpt_pkg::MODE_ICLARKE, sum2 == 0)

endmodule

FILE: rtl/cpt_sincos.sv
// Sine and cosine lookup from a turn-encoded angle using the quarter-wave table.
module cpt_sincos (
  input  logic [cpt_pkg::ANGLE_W-1:0] angle,
  output cpt_pkg::trig_t              trig
);

  localparam int SCALED_W = cpt_pkg::ANGLE_FRAC_W + cpt_pkg::SINE_ADDR_W;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic [1:0]                          quad;
  logic [cpt_pkg::ANGLE_FRAC_W-1:0]    frac;
  logic [SCALED_W-1:0]                 scaled;
  logic [cpt_pkg::SINE_IDX_W-1:0]      idx;
  logic [cpt_pkg::SINE_ADDR_W-1:0]     sin_addr;
  logic [cpt_pkg::SINE_ADDR_W-1:0]     cos_addr;
  logic signed [cpt_pkg::TRIG_W-1:0]   sv;
  logic signed [cpt_pkg::TRIG_W-1:0]   cv;

  assign quad   = angle[cpt_pkg::ANGLE_W-1 -: 2];
  assign frac   = angle[cpt_pkg::ANGLE_FRAC_W-1:0];
  assign scaled = SCALED_W'(frac) * SCALED_W'(cpt_pkg::SINE_TABLE_DEPTH);
  assign idx    = scaled[cpt_pkg::ANGLE_FRAC_W +: cpt_pkg::SINE_IDX_W];

  assign sin_addr = cpt_pkg::SINE_ADDR_W'(idx);
  assign cos_addr = cpt_pkg::SINE_ADDR_W'(cpt_pkg::SINE_TABLE_DEPTH)
                  - cpt_pkg::SINE_ADDR_W'(idx);

  assign sv = cpt_pkg::SINE_TAB[sin_addr];
  assign cv = cpt_pkg::SINE_TAB[cos_addr];

  always_comb begin
    unique case (quad)
      QUAD_0: begin
        trig.sin_val = sv;
        trig.cos_val = cv;
      end
      QUAD_1: begin
        trig.sin_val = cv;
        trig.cos_val = -sv;
      end
      QUAD_2: begin
        trig.sin_val = -sv;
        trig.cos_val = -cv;
      end
      QUAD_3: begin
        trig.sin_val = -cv;
        trig.cos_val = sv;
      end
    endcase
  end

endmodule

FILE: rtl/cpt_round_sat.sv
// Round-half-up right shift and saturation of one wide sum to the output format.
module cpt_round_sat (
  input  logic signed [cpt_pkg::SUM_W-1:0] sum,
  input  logic                             park,
  output cpt_pkg::sat_t                    result
);

  localparam int SW = cpt_pkg::SUM_W;
  localparam logic signed [SW-1:0] SAT_HI =
    (SW'(1) << (cpt_pkg::DATA_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SW-1:0] BIAS_CLARKE = SW'(1) << (cpt_pkg::SHIFT_CLARKE - 1);
  localparam logic signed [SW-1:0] BIAS_PARK   = SW'(1) << (cpt_pkg::SHIFT_PARK - 1);

  logic signed [SW-1:0] biased;
  logic signed [SW-1:0] shifted;

  assign biased  = sum + (park ? BIAS_PARK : BIAS_CLARKE);
  assign shifted = park ? (biased >>> cpt_pkg::SHIFT_PARK)
                        : (biased >>> cpt_pkg::SHIFT_CLARKE);

  always_comb begin
    priority if (shifted > SAT_HI) begin
      result.value = SAT_HI[cpt_pkg::DATA_WIDTH-1:0];
      result.clip  = 1'b1;
    end else if (shifted < SAT_LO) begin
      result.value = SAT_LO[cpt_pkg::DATA_WIDTH-1:0];
      result.clip  = 1'b1;
    end else begin
      result.value = shifted[cpt_pkg::DATA_WIDTH-1:0];
      result.clip  = 1'b0;
    end
  end

endmodule
